### rtl/svm_pkg.sv
`default_nettype none
package svm_pkg;

  localparam int ADDR_W = 16;
  localparam int SVAL_W = 16;
  localparam int LEN_W = 17;
  localparam int GAIN_W = 16;
  localparam int MIX_W = 16;
  localparam int BUSY_W = 4;
  localparam int ACT_W = 2;
  localparam int CLAMP_W = 25;
  localparam int BITCNT_W = 4;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 24;
  localparam int ROUND_SHIFT = 15;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_START,
    ST_TICK_RD,
    ST_TICK_MUL,
    ST_TICK_ACC,
    ST_ROUND,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
    logic rnd;
    logic sat;
  } mac_ctl_t;

endpackage
`default_nettype wire

### rtl/sample_voice_mixer.sv
`default_nettype none
// Multi-voice sample player and mixer. Each input item is one action selected by
// in_tuser: write one sample into the sample memory, start a clip in the lowest
// free voice, mix one output frame, or free all voices; every item yields exactly
// one result item. The block takes one item at a time and drops in_tready until
// the result has been handed to the output register. A frame visits the voices
// in order through the single sample memory read port and the one shared
// multiply-accumulate unit (read, multiply, accumulate for each active voice),
// then rounds and saturates; a start with zero length starts no voice. If
// SAMPLE_MEM_DEPTH is below 65536 and not a power of two, a write or nonzero
// length start first reduces the address modulo the depth, one bit a cycle.
// Mixing sums sample*gain exactly, rounds to Q1.15 (ties up), saturates to
// SAMPLE_BITS and sets the clipped flag when saturation applied. The sample
// memory is not cleared by reset; only written entries may be played.
module sample_voice_mixer #(
  parameter int VOICES = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // mem_address[15:0], sample_value[31:16], clip_length[48:32], gain[64:49]
  input  wire logic [svm_pkg::IN_TDATA_W-1:0]       in_tdata,
  // action[1:0]
  input  wire logic [svm_pkg::ACT_W-1:0]            in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // mixed_sample[15:0], started[16], clipped[17], busy_voices[21:18]
  output logic [svm_pkg::OUT_TDATA_W-1:0]           out_tdata
);
  import svm_pkg::*;

  localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
  localparam int RES_W = MIX_W + 2 + BUSY_W;

  logic                   out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]       out_data_r;
  logic                   out_free;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  mac_ctl_t               mac_ctl;
  logic [GAIN_W-1:0]      mac_gain;
  logic [MIX_W-1:0]       mixed;
  logic                   clipped;
  logic                   done;
  logic                   res_started;
  logic [BUSY_W-1:0]      res_busy;
  action_t                in_action;

  assign in_action = action_t'(in_tuser);
  assign out_free  = !out_valid_r || out_tready;

  svm_seq #(
    .VOICES           (VOICES),
    .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (in_action),
    .in_addr     (in_tdata[15:0]),
    .in_sval     (in_tdata[31:16]),
    .in_len      (in_tdata[48:32]),
    .in_gain     (in_tdata[64:49]),
    .out_free    (out_free),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mac_ctl     (mac_ctl),
    .mac_gain    (mac_gain),
    .done        (done),
    .res_started (res_started),
    .res_busy    (res_busy)
  );

  svm_smem #(
    .DEPTH (SAMPLE_MEM_DEPTH),
    .DW    (SAMPLE_BITS)
  ) u_smem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  svm_mac #(
    .VOICES      (VOICES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .smp       ($signed(mem_rdata)),
    .gain      (mac_gain),
    .mixed_r   (mixed),
    .clipped_r (clipped)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= {res_busy, clipped, res_started, mixed};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_data_r};

endmodule
`default_nettype wire

### rtl/svm_smem.sv
`default_nettype none
module svm_smem #(
  parameter int DEPTH = 65536,
  parameter int DW = 16
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [DW-1:0]             wdata,
  input  wire logic                      re,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [DW-1:0]                  rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/svm_mac.sv
`default_nettype none
module svm_mac #(
  parameter int VOICES = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire svm_pkg::mac_ctl_t                  ctl,
  input  wire logic signed [SAMPLE_BITS-1:0]      smp,
  input  wire logic [svm_pkg::GAIN_W-1:0]         gain,
  output logic [svm_pkg::MIX_W-1:0]               mixed_r,
  output logic                                    clipped_r
);
  import svm_pkg::*;

  localparam int PW = SAMPLE_BITS + GAIN_W + 1;
  localparam int ACC_W = PW + $clog2(VOICES + 1);
  localparam int QW = ACC_W - ROUND_SHIFT;
  localparam logic signed [QW-1:0] Q_MAX = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);
  localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(64'sd1 <<< (ROUND_SHIFT - 1));

  logic signed [PW-1:0]               prod_r;
  logic signed [ACC_W-1:0]            acc_r;
  logic signed [QW-1:0]               q_r;
  logic signed [ACC_W-1:0]            biased;
  logic signed [SAMPLE_BITS-1:0]      sat_val;
  logic                               sat_hit;
  logic [SAMPLE_BITS+MIX_W-1:0]       sat_ext;

  assign biased = acc_r + BIAS;

  always_comb begin
    sat_val = q_r[SAMPLE_BITS-1:0];
    sat_hit = 1'b0;
    if (q_r > Q_MAX) begin
      sat_val = Q_MAX[SAMPLE_BITS-1:0];
      sat_hit = 1'b1;
    end else if (q_r < Q_MIN) begin
      sat_val = Q_MIN[SAMPLE_BITS-1:0];
      sat_hit = 1'b1;
    end
  end

  assign sat_ext = {{MIX_W{sat_val[SAMPLE_BITS-1]}}, sat_val};

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= smp * $signed({1'b0, gain});
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc) begin
      acc_r <= acc_r + {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
    end
    if (ctl.rnd) begin
      q_r <= biased[ACC_W-1:ROUND_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mixed_r   <= '0;
      clipped_r <= 1'b0;
    end else if (ctl.clr) begin
      mixed_r   <= '0;
      clipped_r <= 1'b0;
    end else if (ctl.sat) begin
      mixed_r   <= sat_ext[MIX_W-1:0];
      clipped_r <= sat_hit;
    end
  end

endmodule
`default_nettype wire

### rtl/svm_seq.sv
`default_nettype none
module svm_seq #(
  parameter int VOICES = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire svm_pkg::action_t                      in_action,
  input  wire logic [svm_pkg::ADDR_W-1:0]            in_addr,
  input  wire logic [svm_pkg::SVAL_W-1:0]            in_sval,
  input  wire logic [svm_pkg::LEN_W-1:0]             in_len,
  input  wire logic [svm_pkg::GAIN_W-1:0]            in_gain,
  input  wire logic                                  out_free,
  output logic                                       mem_we,
  output logic [$clog2(SAMPLE_MEM_DEPTH)-1:0]        mem_waddr,
  output logic [SAMPLE_BITS-1:0]                     mem_wdata,
  output logic                                       mem_re,
  output logic [$clog2(SAMPLE_MEM_DEPTH)-1:0]        mem_raddr,
  output svm_pkg::mac_ctl_t                          mac_ctl,
  output logic [svm_pkg::GAIN_W-1:0]                 mac_gain,
  output logic                                       done,
  output logic                                       res_started,
  output logic [svm_pkg::BUSY_W-1:0]                 res_busy
);
  import svm_pkg::*;

  localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam bit POW2 = (SAMPLE_MEM_DEPTH & (SAMPLE_MEM_DEPTH - 1)) == 0;
  localparam bit NO_RED = POW2 || (SAMPLE_MEM_DEPTH > 65535);
  localparam logic [AW:0] DEPTH_C = (AW+1)'(SAMPLE_MEM_DEPTH);
  localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);
  localparam logic signed [CLAMP_W-1:0] SMP_MAX =
    CLAMP_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [CLAMP_W-1:0] SMP_MIN = -SMP_MAX - CLAMP_W'(1);

  state_t state_r, state_nxt;

  action_t               act_r;
  logic [ADDR_W-1:0]     sh_r;
  logic [SVAL_W-1:0]     sval_r;
  logic [LEN_W-1:0]      len_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [AW:0]           red_r;
  logic [BITCNT_W-1:0]   bitc_r;
  logic [VW-1:0]         v_r;

  logic [VOICES-1:0]     on_r;
  logic [AW-1:0]         ptr_r  [VOICES];
  logic [LEN_W-1:0]      left_r [VOICES];
  logic [GAIN_W-1:0]     vgain_r [VOICES];
  logic [CW-1:0]         cnt_r;
  logic                  started_r;

  logic                  accept;
  logic [AW+ADDR_W-1:0]  addr_ext;
  logic [AW:0]           red_try;
  logic [AW:0]           red_step;
  logic [AW:0]           ptr_inc;
  logic [AW-1:0]         ptr_next;
  logic [LEN_W-1:0]      left_dec;
  logic signed [CLAMP_W-1:0] sval_ext;
  logic signed [CLAMP_W-1:0] sval_clamp;
  logic [CW+BUSY_W-1:0]  cnt_ext;
  logic                  last_v;

  assign accept   = in_valid && in_ready;
  assign addr_ext = {{AW{1'b0}}, in_addr};
  assign red_try  = {red_r[AW-1:0], sh_r[ADDR_W-1]};
  assign red_step = (red_try >= DEPTH_C) ? red_try - DEPTH_C : red_try;
  assign ptr_inc  = {1'b0, ptr_r[v_r]} + (AW+1)'(1);
  assign ptr_next = (ptr_inc == DEPTH_C) ? '0 : ptr_inc[AW-1:0];
  assign left_dec = (left_r[v_r] == '0) ? '0 : left_r[v_r] - LEN_W'(1);
  assign last_v   = (v_r == LAST_V);
  assign cnt_ext  = {{BUSY_W{1'b0}}, cnt_r};

  assign sval_ext = {{(CLAMP_W-SVAL_W){sval_r[SVAL_W-1]}}, sval_r};
  always_comb begin
    sval_clamp = sval_ext;
    if (sval_ext > SMP_MAX) begin
      sval_clamp = SMP_MAX;
    end else if (sval_ext < SMP_MIN) begin
      sval_clamp = SMP_MIN;
    end
  end

  assign mem_waddr   = red_r[AW-1:0];
  assign mem_wdata   = sval_clamp[SAMPLE_BITS-1:0];
  assign mem_raddr   = ptr_r[v_r];
  assign mac_gain    = vgain_r[v_r];
  assign res_started = started_r;
  assign res_busy    = cnt_ext[BUSY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mac_ctl   = '0;
    done      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mac_ctl.clr = 1'b1;
          case (in_action)
            ACT_WRITE: state_nxt = NO_RED ? ST_WRITE : ST_REDUCE;
            ACT_START: begin
              if (in_len == '0) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = NO_RED ? ST_START : ST_REDUCE;
              end
            end
            ACT_TICK: state_nxt = ST_TICK_RD;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_REDUCE: begin
        if (bitc_r == '1) begin
          state_nxt = (act_r == ACT_WRITE) ? ST_WRITE : ST_START;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_START: begin
        if (!on_r[v_r] || last_v) begin
          state_nxt = ST_DONE;
        end
      end
      ST_TICK_RD: begin
        if (on_r[v_r]) begin
          mem_re    = 1'b1;
          state_nxt = ST_TICK_MUL;
        end else if (last_v) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_TICK_MUL: begin
        mac_ctl.mul = 1'b1;
        state_nxt   = ST_TICK_ACC;
      end
      ST_TICK_ACC: begin
        mac_ctl.acc = 1'b1;
        state_nxt   = last_v ? ST_ROUND : ST_TICK_RD;
      end
      ST_ROUND: begin
        mac_ctl.rnd = 1'b1;
        state_nxt   = ST_SAT;
      end
      ST_SAT: begin
        mac_ctl.sat = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r      <= '0;
      cnt_r     <= '0;
      started_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            started_r <= 1'b0;
            if (in_action == ACT_CLEAR) begin
              on_r  <= '0;
              cnt_r <= '0;
            end
          end
        end
        ST_START: begin
          if (!on_r[v_r]) begin
            on_r[v_r] <= 1'b1;
            cnt_r     <= cnt_r + CW'(1);
            started_r <= 1'b1;
          end
        end
        ST_TICK_ACC: begin
          if (left_dec == '0) begin
            on_r[v_r] <= 1'b0;
            cnt_r     <= cnt_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_r  <= in_action;
          sh_r   <= in_addr;
          sval_r <= in_sval;
          len_r  <= in_len;
          gain_r <= in_gain;
          bitc_r <= '0;
          v_r    <= '0;
          red_r  <= NO_RED ? {1'b0, addr_ext[AW-1:0]} : '0;
        end
      end
      ST_REDUCE: begin
        red_r  <= red_step;
        sh_r   <= {sh_r[ADDR_W-2:0], 1'b0};
        bitc_r <= bitc_r + BITCNT_W'(1);
      end
      ST_START: begin
        if (!on_r[v_r]) begin
          ptr_r[v_r]   <= red_r[AW-1:0];
          left_r[v_r]  <= len_r;
          vgain_r[v_r] <= gain_r;
        end else if (!last_v) begin
          v_r <= v_r + VW'(1);
        end
      end
      ST_TICK_RD: begin
        if (!on_r[v_r] && !last_v) begin
          v_r <= v_r + VW'(1);
        end
      end
      ST_TICK_ACC: begin
        ptr_r[v_r]  <= ptr_next;
        left_r[v_r] <= left_dec;
        if (!last_v) begin
          v_r <= v_r + VW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
